// ===== hw/rtl/quaternion_vector_rotate_core_assert.svh =====
// ----------------------------------------------------------------------------
// quaternion vector rotate assertion macros
// shared property wrappers for the rotate core checker
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QVR_ASSERT_IMP(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define QVR_ASSERT_NXT(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// constants and register codes of the quaternion vector rotate core
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  // quaternion component width (fixed by the register map)
  localparam int QUAT_W = 16;

  // parameter defaults
  localparam int VEC_WIDTH_DEF      = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // configuration register index width
  localparam int CFG_IDX_W = 2;

  // reset value of the scalar part (1.0 in Q2.14)
  localparam logic signed [QUAT_W-1:0] QUAT_W_RESET = 16'sd16384;

  // register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/quaternion_vector_rotate_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// rotates a stream of 3-D vectors by a quaternion held in registers
// ----------------------------------------------------------------------------
// a vector passes the input, product, row-sum and output registers in turn
// throughput: one vector per cycle while the output is not stalled, set by the fully pipelined 3x3 multiply
// quaternion writes reach the rotation matrix register through the quaternion registers
// synchronous active-low reset clears valid bits and loads the identity
// quaternion (w = 1.0, x = y = z = 0)
`default_nettype none

module quaternion_vector_rotate_core #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qvr_pkg::QUAT_W-1:0]          cfg_data,
  // input vector channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [VEC_WIDTH-1:0]         out_rot_x,
  output logic signed [VEC_WIDTH-1:0]         out_rot_y,
  output logic signed [VEC_WIDTH-1:0]         out_rot_z,
  output logic                                out_saturated
);

  import qvr_pkg::*;

  // result scaling: matrix entries carry 2F-1 fraction bits
  localparam int SHIFT  = 2 * QUAT_FRAC_BITS - 1;
  localparam int COEF_W = (2 * QUAT_W + 1 > SHIFT + 2) ? 2 * QUAT_W + 1 : SHIFT + 2;
  localparam int PROD_W = COEF_W + VEC_WIDTH;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [COEF_W-1:0] ONE_C = COEF_W'(1) << SHIFT;
  localparam logic signed [SUM_W-1:0]  RND_C = SUM_W'(1) << (SHIFT - 1);
  localparam logic signed [SUM_W-1:0]  VMAX_S =
    {{(SUM_W - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  VMIN_S =
    {{(SUM_W - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};

  // quaternion registers
  logic signed [QUAT_W-1:0] quat_w_r, quat_x_r, quat_y_r, quat_z_r;

  // rotation matrix, diagonal already holds the minus-identity term
  logic signed [COEF_W-1:0] mat_r   [3][3];
  logic signed [COEF_W-1:0] mat_nxt [3][3];

  // pipeline stages
  logic                        vld1_r, vld2_r, vld3_r, out_valid_r;
  logic signed [VEC_WIDTH-1:0] vec1_r  [3];
  logic signed [PROD_W-1:0]    prod2_r [3][3];
  logic signed [SUM_W-1:0]     sum3_r  [3];
  logic signed [SUM_W-1:0]     sum3_nxt [3];
  logic signed [VEC_WIDTH-1:0] rot_r   [3];
  logic signed [VEC_WIDTH-1:0] rot_nxt [3];
  logic                        sat_r, sat_nxt;

  // per-stage advance enables, bubbles collapse behind a stalled output
  logic en1, en2, en3, en4;

  // quaternion component products
  logic signed [2*QUAT_W-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  // configuration transfer, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_w_r <= QUAT_W_RESET;
      quat_x_r <= '0;
      quat_y_r <= '0;
      quat_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_W: quat_w_r <= cfg_data;
        REG_QUAT_X: quat_x_r <= cfg_data;
        REG_QUAT_Y: quat_y_r <= cfg_data;
        REG_QUAT_Z: quat_z_r <= cfg_data;
        default:    quat_w_r <= quat_w_r;
      endcase
    end
  end

  // matrix from quaternion products
  always_comb begin
    p_ww = quat_w_r * quat_w_r;
    p_xx = quat_x_r * quat_x_r;
    p_yy = quat_y_r * quat_y_r;
    p_zz = quat_z_r * quat_z_r;
    p_xy = quat_x_r * quat_y_r;
    p_xz = quat_x_r * quat_z_r;
    p_yz = quat_y_r * quat_z_r;
    p_wx = quat_w_r * quat_x_r;
    p_wy = quat_w_r * quat_y_r;
    p_wz = quat_w_r * quat_z_r;

    mat_nxt[0][0] = COEF_W'(p_ww) + COEF_W'(p_xx) - ONE_C;
    mat_nxt[0][1] = COEF_W'(p_xy) - COEF_W'(p_wz);
    mat_nxt[0][2] = COEF_W'(p_xz) + COEF_W'(p_wy);
    mat_nxt[1][0] = COEF_W'(p_xy) + COEF_W'(p_wz);
    mat_nxt[1][1] = COEF_W'(p_ww) + COEF_W'(p_yy) - ONE_C;
    mat_nxt[1][2] = COEF_W'(p_yz) - COEF_W'(p_wx);
    mat_nxt[2][0] = COEF_W'(p_xz) - COEF_W'(p_wy);
    mat_nxt[2][1] = COEF_W'(p_yz) + COEF_W'(p_wx);
    mat_nxt[2][2] = COEF_W'(p_ww) + COEF_W'(p_zz) - ONE_C;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_r[i][j] <= mat_nxt[i][j];
      end
    end
  end

  // stall chain
  assign en4      = !out_valid_r || !out_stall;
  assign en3      = !vld3_r || en4;
  assign en2      = !vld2_r || en3;
  assign en1      = !vld1_r || en2;
  assign in_stall = !en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) vld1_r      <= in_valid;
      if (en2) vld2_r      <= vld1_r;
      if (en3) vld3_r      <= vld2_r;
      if (en4) out_valid_r <= vld3_r;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (en1) begin
      vec1_r[0] <= in_vec_x;
      vec1_r[1] <= in_vec_y;
      vec1_r[2] <= in_vec_z;
    end
  end

  // stage 2: nine matrix-vector products
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod2_r[i][j] <= mat_r[i][j] * vec1_r[j];
        end
      end
    end
  end

  // stage 3: row sums plus rounding offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum3_nxt[i] = SUM_W'(prod2_r[i][0]) + SUM_W'(prod2_r[i][1])
                  + SUM_W'(prod2_r[i][2]) + RND_C;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        sum3_r[i] <= sum3_nxt[i];
      end
    end
  end

  // stage 4: scale down and clip
  always_comb begin
    logic signed [SUM_W-1:0] q;
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = sum3_r[i] >>> SHIFT;
      if (q > VMAX_S) begin
        rot_nxt[i] = VMAX_S[VEC_WIDTH-1:0];
        sat_nxt    = 1'b1;
      end else if (q < VMIN_S) begin
        rot_nxt[i] = VMIN_S[VEC_WIDTH-1:0];
        sat_nxt    = 1'b1;
      end else begin
        rot_nxt[i] = q[VEC_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        rot_r[i] <= rot_nxt[i];
      end
      sat_r <= sat_nxt;
    end
  end

  // outputs
  assign out_valid     = out_valid_r;
  assign out_rot_x     = rot_r[0];
  assign out_rot_y     = rot_r[1];
  assign out_rot_z     = rot_r[2];
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker
// port-level checks of the quaternion vector rotate core
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_vector_rotate_core_assert.svh"

module qvr_checker #(
  parameter int VEC_WIDTH = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [VEC_WIDTH-1:0] out_rot_x,
  input logic [VEC_WIDTH-1:0] out_rot_y,
  input logic [VEC_WIDTH-1:0] out_rot_z,
  input logic                 out_saturated
);

  localparam logic [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

  // a stalled result transfer holds its payload
  `QVR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_rot_x) && $stable(out_rot_y) && $stable(out_rot_z) && $stable(out_saturated))

  // input backs up only when the result register is full and stalled
  `QVR_ASSERT_IMP(a_in_stall_src, clk, rst_n, in_stall, out_valid && out_stall)

  // a clipped result shows at least one component at a range limit
  `QVR_ASSERT_IMP(a_sat_limit, clk, rst_n, out_valid && out_saturated, out_rot_x == VMAX || out_rot_x == VMIN || out_rot_y == VMAX || out_rot_y == VMIN || out_rot_z == VMAX || out_rot_z == VMIN)

  // offered input that is held back always has a result waiting
  logic in_seen;
  assign in_seen = in_valid;

  `QVR_ASSERT_IMP(a_in_stall_valid_free, clk, rst_n, in_seen && in_stall, out_valid)

endmodule

bind quaternion_vector_rotate_core qvr_checker #(
  .VEC_WIDTH(VEC_WIDTH)
) u_qvr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_rot_x    (out_rot_x),
  .out_rot_y    (out_rot_y),
  .out_rot_z    (out_rot_z),
  .out_saturated(out_saturated)
);

`default_nettype wire
